[rtl/ipv4dq_pkg.sv]
// Shared types for the IPv4 dotted-quad parser: request, response and parse phase.
package ipv4dq_pkg;

  // One character of the address text.
  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } ipv4dq_req_t;

  // One verdict per string.
  typedef struct packed {
    logic        valid_res;
    logic [31:0] address;
  } ipv4dq_rsp_t;

  typedef enum logic [6:0] {
    PH_LEAD  = 7'b0000001,
    PH_ANY_N = 7'b0000010,
    PH_ANY_Y = 7'b0000100,
    PH_OCTET = 7'b0001000,
    PH_DOT   = 7'b0010000,
    PH_TRAIL = 7'b0100000,
    PH_FAIL  = 7'b1000000
  } ipv4dq_phase_t;

endpackage

[rtl/ipv4_dotted_quad_parser.sv]
// Top level of the IPv4 dotted-quad text parser.
//
// Request channel (req_valid/req_ready/req): one character of address text per
// request, with is_last set on the final character of a string. Response
// channel (rsp_valid/rsp_ready/rsp): one verdict per string, valid_res plus the
// 32-bit address, first octet in the top byte; address reads 0 when invalid
// and for the keyword "any". Leading and trailing spaces and tabs are ignored.
//
// Path: a last character is accepted into the input register; one pass of the
// parse logic then writes its verdict into the result register, which drives
// rsp. Throughput: one character per cycle, except while a last character waits
// in the input register for the result register to free.
//
// Reset clears both registers' valid flags and returns the parser to the
// leading-blank phase. When the receiver stalls, characters that do not end
// a string keep flowing; a last character waits in the input register until
// the result register frees, and req_ready drops only then.
module ipv4_dotted_quad_parser import ipv4dq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  ipv4dq_req_t req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output ipv4dq_rsp_t rsp
);

  logic        q_valid;
  ipv4dq_req_t q;
  logic        take;
  logic        push;
  logic        out_free;
  ipv4dq_rsp_t result;

  // Hold the incoming character.
  ipv4dq_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .take      (take),
    .q_valid   (q_valid),
    .q         (q)
  );

  // Advance the parse state; form the verdict on the last character.
  ipv4dq_core u_core (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q        (q),
    .out_free (out_free),
    .take     (take),
    .push     (push),
    .result   (result)
  );

  // Hold the verdict for the receiver.
  ipv4dq_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .result    (result),
    .out_free  (out_free),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // A verdict is only written into a free result register.
  assert property (@(posedge clk) disable iff (rst)
    push |-> (!rsp_valid || rsp_ready))
    else $error("verdict written over an unread result");

  // Taking a last character raises rsp_valid on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    push |=> rsp_valid)
    else $error("verdict lost after last character");

  // An empty input register always accepts a request.
  assert property (@(posedge clk) disable iff (rst)
    !q_valid |-> req_ready)
    else $error("empty input register refused a request");

  // A rejected string reports a zero address.
  assert property (@(posedge clk) disable iff (rst)
    (push && !result.valid_res) |=> (rsp.address == '0))
    else $error("invalid verdict carries a nonzero address");

endmodule

[rtl/ipv4dq_in_reg.sv]
// Input register: holds one request until the parse core takes it.
module ipv4dq_in_reg import ipv4dq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  ipv4dq_req_t req,
  input  logic        take,
  output logic        q_valid,
  output ipv4dq_req_t q
);

  // Accept while empty or while the held request moves on this cycle.
  assign req_ready = !q_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (req_ready) begin
      q_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      q <= req;
    end
  end

endmodule

[rtl/ipv4dq_core.sv]
// Parse core: per-character state update and verdict on the last character.
module ipv4dq_core import ipv4dq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  ipv4dq_req_t q,
  input  logic        out_free,
  output logic        take,
  output logic        push,
  output ipv4dq_rsp_t result
);

  localparam logic [7:0]  CH_SPACE   = 8'h20;
  localparam logic [7:0]  CH_TAB     = 8'h09;
  localparam logic [7:0]  CH_DOT     = 8'h2E;
  localparam logic [7:0]  CH_ZERO    = 8'h30;
  localparam logic [7:0]  CH_NINE    = 8'h39;
  localparam logic [7:0]  CH_UPPER_A = 8'h41;
  localparam logic [7:0]  CH_UPPER_Z = 8'h5A;
  localparam logic [7:0]  CASE_BIT   = 8'h20;
  localparam logic [7:0]  CH_LOW_A   = 8'h61;
  localparam logic [7:0]  CH_LOW_N   = 8'h6E;
  localparam logic [7:0]  CH_LOW_Y   = 8'h79;
  localparam logic [11:0] OCTET_MAX  = 12'd255;
  localparam logic [1:0]  LAST_OCTET = 2'd3;
  localparam logic [1:0]  MAX_DIGITS = 2'd3;

  ipv4dq_phase_t phase, phase_next;
  logic [1:0]    octet_index, octet_index_next;
  logic [1:0]    digit_count, digit_count_next;
  logic [7:0]    octet_value, octet_value_next;
  logic [23:0]   address_high, address_high_next;
  logic          content_complete, content_complete_next;

  logic [7:0]  c;
  logic [7:0]  c_low;
  logic        c_blank;
  logic        c_digit;
  logic [11:0] acc;
  logic        ok;

  assign c       = q.char_code;
  assign c_blank = (c == CH_SPACE) || (c == CH_TAB);
  assign c_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign c_low   = ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ? (c | CASE_BIT) : c;
  // value * 10 + digit, as shifts and adds
  assign acc = {1'b0, octet_value, 3'b000} + {3'b000, octet_value, 1'b0}
             + {8'b0, c[3:0]};

  // A last character needs room in the result register; others pass freely.
  assign take = q_valid && (!q.is_last || out_free);
  assign push = take && q.is_last;

  always_comb begin
    phase_next            = phase;
    octet_index_next      = octet_index;
    digit_count_next      = digit_count;
    octet_value_next      = octet_value;
    address_high_next     = address_high;
    content_complete_next = content_complete;
    case (phase)
      PH_LEAD: begin
        if (c_blank) begin
          phase_next = PH_LEAD;
        end else if (c_low == CH_LOW_A) begin
          phase_next = PH_ANY_N;
        end else if (c_digit) begin
          phase_next            = PH_OCTET;
          octet_value_next      = {4'b0, c[3:0]};
          digit_count_next      = 2'd1;
          content_complete_next = (octet_index == LAST_OCTET);
        end else begin
          phase_next            = PH_FAIL;
          content_complete_next = 1'b0;
        end
      end
      PH_ANY_N: begin
        if (c_low == CH_LOW_N) begin
          phase_next = PH_ANY_Y;
        end else begin
          phase_next            = PH_FAIL;
          content_complete_next = 1'b0;
        end
      end
      PH_ANY_Y: begin
        if (c_low == CH_LOW_Y) begin
          phase_next            = PH_TRAIL;
          address_high_next     = '0;
          octet_value_next      = '0;
          content_complete_next = 1'b1;
        end else begin
          phase_next            = PH_FAIL;
          content_complete_next = 1'b0;
        end
      end
      PH_OCTET: begin
        if (c_digit) begin
          if ((digit_count >= MAX_DIGITS) || (acc > OCTET_MAX)) begin
            phase_next            = PH_FAIL;
            content_complete_next = 1'b0;
          end else begin
            octet_value_next = acc[7:0];
            digit_count_next = digit_count + 2'd1;
          end
        end else if ((c == CH_DOT) && (octet_index != LAST_OCTET)) begin
          address_high_next     = {address_high[15:0], octet_value};
          octet_index_next      = octet_index + 2'd1;
          octet_value_next      = '0;
          digit_count_next      = '0;
          content_complete_next = 1'b0;
          phase_next            = PH_DOT;
        end else if (c_blank && (octet_index == LAST_OCTET)) begin
          phase_next = PH_TRAIL;
        end else begin
          phase_next            = PH_FAIL;
          content_complete_next = 1'b0;
        end
      end
      PH_DOT: begin
        if (c_digit) begin
          phase_next            = PH_OCTET;
          octet_value_next      = {4'b0, c[3:0]};
          digit_count_next      = 2'd1;
          content_complete_next = (octet_index == LAST_OCTET);
        end else begin
          phase_next            = PH_FAIL;
          content_complete_next = 1'b0;
        end
      end
      PH_TRAIL: begin
        if (!c_blank) begin
          phase_next            = PH_FAIL;
          content_complete_next = 1'b0;
        end
      end
      default: begin
        phase_next            = PH_FAIL;
        content_complete_next = 1'b0;
      end
    endcase
  end

  assign ok               = content_complete_next && (phase_next != PH_FAIL);
  assign result.valid_res = ok;
  assign result.address   = ok ? {address_high_next, octet_value_next} : '0;

  // Advance on every taken character; drop back to the start after the last one.
  always_ff @(posedge clk) begin
    if (rst || push) begin
      phase            <= PH_LEAD;
      octet_index      <= '0;
      digit_count      <= '0;
      octet_value      <= '0;
      address_high     <= '0;
      content_complete <= 1'b0;
    end else if (take) begin
      phase            <= phase_next;
      octet_index      <= octet_index_next;
      digit_count      <= digit_count_next;
      octet_value      <= octet_value_next;
      address_high     <= address_high_next;
      content_complete <= content_complete_next;
    end
  end

endmodule

[rtl/ipv4dq_out_reg.sv]
// Result register: holds one verdict until the receiver takes it.
module ipv4dq_out_reg import ipv4dq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  ipv4dq_rsp_t result,
  output logic        out_free,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output ipv4dq_rsp_t rsp
);

  assign out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (push) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rsp <= result;
    end
  end

endmodule

[tb/tb_ipv4_dotted_quad_parser.sv]
// Testbench for the IPv4 dotted-quad text parser: self-checking, random and directed strings.
module tb_ipv4_dotted_quad_parser import ipv4dq_pkg::*;;

  // Character codes the parser treats specially.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_Y     = 8'h79;

  // Cycles with no handshake on either side before the run is declared hung.
  localparam int STALL_LIMIT  = 2000;
  // Cycles to linger once every verdict has arrived; covers the two register stages.
  localparam int DRAIN_CYCLES = 8;
  // Characters to send in the random part.
  localparam int RANDOM_CHARS = 1950;

  // Receiver behavior, picked anew at random now and then.
  typedef enum logic [1:0] {
    RX_OPEN,    // always ready
    RX_COIN,    // ready half the time
    RX_SPARSE,  // ready at random, with odds of one in eight
    RX_COMB     // fixed pattern: ready while the 3-bit phase counter is below 3
  } rx_mode_t;

  // Tracks the parse of the current string and holds the verdicts still owed.
  class quad_verdict_tracker;
    ipv4dq_phase_t phase;
    logic [1:0]    octet_idx;
    logic [1:0]    digit_cnt;
    logic [7:0]    octet_val;
    logic [23:0]   addr_high;
    logic          token_done;
    ipv4dq_rsp_t   pending[$];
    int            failures;

    function new();
      clear();
      failures = 0;
    endfunction

    function void clear();
      phase      = PH_LEAD;
      octet_idx  = '0;
      digit_cnt  = '0;
      octet_val  = '0;
      addr_high  = '0;
      token_done = 1'b0;
    endfunction

    function void fail_parse();
      phase      = PH_FAIL;
      token_done = 1'b0;
    endfunction

    function void open_octet(logic [7:0] c);
      phase      = PH_OCTET;
      octet_val  = c - CH_ZERO;
      digit_cnt  = 2'd1;
      token_done = (octet_idx == 2'd3);
    endfunction

    // Advance the parse by one accepted character; owe a verdict on the last one.
    function void take_char(ipv4dq_req_t r);
      logic [7:0]  c;
      logic [7:0]  low;
      logic        blank;
      logic        digit;
      int          v;
      ipv4dq_rsp_t verdict;
      c     = r.char_code;
      low   = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
      blank = (c == CH_SPACE) || (c == CH_TAB);
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      case (phase)
        PH_LEAD: begin
          if (!blank) begin
            if (low == CH_A) phase = PH_ANY_N;
            else if (digit) open_octet(c);
            else fail_parse();
          end
        end
        PH_ANY_N: begin
          if (low == CH_N) phase = PH_ANY_Y;
          else fail_parse();
        end
        PH_ANY_Y: begin
          if (low == CH_Y) begin
            phase      = PH_TRAIL;
            addr_high  = '0;
            octet_val  = '0;
            token_done = 1'b1;
          end else begin
            fail_parse();
          end
        end
        PH_OCTET: begin
          if (digit) begin
            v = int'(octet_val) * 10 + int'(c) - int'(CH_ZERO);
            if (digit_cnt >= 2'd3 || v > 255) begin
              fail_parse();
            end else begin
              octet_val = v[7:0];
              digit_cnt = digit_cnt + 2'd1;
            end
          end else if (c == CH_DOT && octet_idx < 2'd3) begin
            addr_high  = {addr_high[15:0], octet_val};
            octet_idx  = octet_idx + 2'd1;
            octet_val  = '0;
            digit_cnt  = '0;
            token_done = 1'b0;
            phase      = PH_DOT;
          end else if (blank && octet_idx == 2'd3) begin
            phase = PH_TRAIL;
          end else begin
            fail_parse();
          end
        end
        PH_DOT: begin
          if (digit) open_octet(c);
          else fail_parse();
        end
        PH_TRAIL: begin
          if (!blank) fail_parse();
        end
        default: fail_parse();
      endcase
      if (r.is_last) begin
        verdict.valid_res = token_done && (phase != PH_FAIL);
        verdict.address   = verdict.valid_res ? {addr_high, octet_val} : 32'd0;
        pending.push_back(verdict);
        clear();
      end
    endfunction

    // Compare one delivered verdict with the oldest one owed.
    function void check_verdict(ipv4dq_rsp_t got);
      ipv4dq_rsp_t want;
      if (pending.size() == 0) begin
        $display("%0t: verdict with none expected: valid_res %0b address %h",
                 $time, got.valid_res, got.address);
        failures++;
        return;
      end
      want = pending.pop_front();
      if (got.valid_res !== want.valid_res) begin
        $display("%0t: valid_res mismatch: expected %0b actual %0b",
                 $time, want.valid_res, got.valid_res);
        failures++;
      end
      if (got.address !== want.address) begin
        $display("%0t: address mismatch: expected %h actual %h",
                 $time, want.address, got.address);
        failures++;
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  ipv4dq_req_t req       = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  ipv4dq_rsp_t rsp;

  quad_verdict_tracker tracker;

  logic [7:0] text[$];       // string being assembled for the next send
  int         chars_sent  = 0;
  int         burst_left  = 0;
  int         quiet_cycles = 0;
  rx_mode_t   rx_mode     = RX_OPEN;
  int         rx_left     = 0;
  logic [2:0] rx_phase    = '0;

  ipv4_dotted_quad_parser dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every verdict the receiver accepts; skip while reset is held.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) tracker.check_verdict(rsp);
  end

  // Receiver: hold one stall pattern for a random stretch, then pick another.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(64, 256);
    end
    rx_left--;
    rx_phase = rx_phase + 3'd1;
    case (rx_mode)
      RX_OPEN:   rsp_ready = 1'b1;
      RX_COIN:   rsp_ready = 1'($urandom_range(0, 1));
      RX_SPARSE: rsp_ready = ($urandom_range(0, 7) == 0);
      default:   rsp_ready = (rx_phase < 3'd3);
    endcase
  end

  // Watchdog: end the run if no request and no verdict moves for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Drive one character; hold it until accepted. Insert sender gaps between bursts.
  task automatic send_char(input logic [7:0] c, input logic last);
    ipv4dq_req_t r;
    r.char_code = c;
    r.is_last   = last;
    @(negedge clk);
    if (burst_left == 0) begin
      // Drop valid for a gap: mostly short, now and then long.
      req_valid = 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4))
        @(negedge clk);
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    req       = r;
    req_valid = 1'b1;
    do @(posedge clk); while (!req_ready);
    tracker.take_char(r);
    chars_sent++;
  endtask

  // Send the assembled string with the last flag on its final character, then clear it.
  task automatic send_text();
    for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
    text.delete();
  endtask

  task automatic put(input string s);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endtask

  task automatic send_string(input string s);
    put(s);
    send_text();
  endtask

  // Stop sending and wait until every verdict owed has come back.
  task automatic hold_until_drained();
    @(negedge clk);
    req_valid = 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
  endtask

  task automatic push_blanks(input int n);
    repeat (n) text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endtask

  // Append v in decimal using exactly ndig digits (leading zeros as needed).
  task automatic push_octet(input int v, input int ndig);
    int p;
    p = 1;
    repeat (ndig - 1) p = p * 10;
    for (int k = 0; k < ndig; k++) begin
      text.push_back(CH_ZERO + 8'((v / p) % 10));
      p = p / 10;
    end
  endtask

  // Build a dotted string of n octets; with overflow set one octet exceeds 255.
  task automatic build_quad(input int n, input bit overflow);
    int v;
    int min_dig;
    int bad_idx;
    bad_idx = $urandom_range(0, n - 1);
    push_blanks(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
    for (int i = 0; i < n; i++) begin
      if (i > 0) text.push_back(CH_DOT);
      case ($urandom_range(0, 5))
        0:       v = 0;
        1:       v = 255;
        2:       v = $urandom_range(0, 9);
        3:       v = $urandom_range(0, 99);
        default: v = $urandom_range(0, 255);
      endcase
      if (overflow && i == bad_idx) v = $urandom_range(256, 999);
      min_dig = (v < 10) ? 1 : (v < 100) ? 2 : 3;
      push_octet(v, $urandom_range(min_dig, 3));
    end
    push_blanks(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
  endtask

  // Build the keyword in random letter case, sometimes broken.
  task automatic build_any();
    push_blanks($urandom_range(0, 2));
    text.push_back(8'h41 | ($urandom_range(0, 1) ? 8'h20 : 8'h00));
    text.push_back(8'h4E | ($urandom_range(0, 1) ? 8'h20 : 8'h00));
    text.push_back(8'h59 | ($urandom_range(0, 1) ? 8'h20 : 8'h00));
    case ($urandom_range(0, 5))
      0:       text.delete(text.size() - 1);
      1:       text.push_back(8'($urandom_range(0, 255)));
      default: ;
    endcase
    push_blanks($urandom_range(0, 2));
  endtask

  // Damage a well-formed string at one spot: overwrite, insert or delete a character.
  task automatic corrupt_text();
    int pos;
    pos = $urandom_range(0, text.size() - 1);
    case ($urandom_range(0, 2))
      0: text[pos] = 8'($urandom_range(0, 255));
      1: begin
        case ($urandom_range(0, 3))
          0:       text.insert(pos, CH_DOT);
          1:       text.insert(pos, CH_SPACE);
          2:       text.insert(pos, CH_ZERO + 8'($urandom_range(0, 9)));
          default: text.insert(pos, 8'($urandom_range(0, 255)));
        endcase
      end
      default: if (text.size() > 1) text.delete(pos);
    endcase
  endtask

  // Pick one random string: mostly well-formed quads, the rest keywords, broken quads or noise.
  task automatic build_random_text();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      build_quad(4, 1'b0);
    end else if (kind < 65) begin
      build_quad(4, 1'b0);
      corrupt_text();
    end else if (kind < 70) begin
      build_quad(4, 1'b1);
    end else if (kind < 78) begin
      build_any();
    end else if (kind < 84) begin
      build_quad($urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(5, 6), 1'b0);
    end else if (kind < 93) begin
      repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      push_blanks($urandom_range(1, 4));
    end
  endtask

  initial begin
    int random_start;
    bit paused;
    tracker = new();
    paused  = 1'b0;
    // Hold reset, then release it on a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed strings: extremes, keyword, and the named corner cases.
    send_string("0.0.0.0");
    send_string("255.255.255.255");
    send_string("099.249.250.001");
    send_string(" \tAnY\t ");
    send_string(" \t ");          // blank only
    send_string("1.2.3.4 x");     // text after trailing blanks
    put("10.20.30.");             // byte above the ASCII range
    text.push_back(8'hFF);
    send_text();
    send_string("256.0.0.0");
    send_string("0001.2.3.4");
    send_string("1.2.3");
    send_string("1.2.3.4.5");
    send_string("1..2.3");
    send_string("1.2 .3.4");
    send_string("ax1.2.3.4");     // error, then bytes ignored up to the last
    send_string("anyx");
    send_string("an");
    send_string("7");
    send_string(".");
    hold_until_drained();

    // Random strings until enough characters have gone through.
    random_start = chars_sent;
    while (chars_sent - random_start < RANDOM_CHARS) begin
      build_random_text();
      send_text();
      if (!paused && chars_sent - random_start >= RANDOM_CHARS / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
    end

    // Drain: wait for every owed verdict, then linger past the pipeline latency.
    @(negedge clk);
    req_valid = 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ipv4dq_pkg.sv
rtl/ipv4dq_in_reg.sv
rtl/ipv4dq_core.sv
rtl/ipv4dq_out_reg.sv
rtl/ipv4_dotted_quad_parser.sv
tb/tb_ipv4_dotted_quad_parser.sv
